/* rtl/rfa_pkg.sv */
`default_nettype none
package rfa_pkg;

   localparam int MEM_DEPTH = 65536;
   localparam int MEM_AW    = $clog2(MEM_DEPTH);

   typedef enum logic [3:0] {
      CMD_WRB = 4'd0,
      CMD_RDB = 4'd1,
      CMD_LDR = 4'd2,
      CMD_STR = 4'd3,
      CMD_CMR = 4'd4,
      CMD_AMR = 4'd5,
      CMD_SMR = 4'd6,
      CMD_LA  = 4'd7,
      CMD_SR  = 4'd8,
      CMD_SL  = 4'd9,
      CMD_MVQ = 4'd10,
      CMD_CMQ = 4'd11
   } cmd_type;

   typedef struct packed {
      logic [3:0]  command;
      logic [15:0] reg_value;
      logic [15:0] operand;
      logic [15:0] addr_a;
      logic [15:0] addr_b;
      logic [15:0] length;
      logic [7:0]  byte_value;
   } req_type;

   typedef struct packed {
      logic [15:0] reg_out;
      logic        reg_valid;
      logic [1:0]  cond_code;
      logic        carry_high;
      logic        carry_into_msb;
      logic [7:0]  read_data;
   } rsp_type;

   // classified word handed from front to back
   typedef struct packed {
      req_type     req;
      logic        is_mem;   // needs the memory walker
   } job_type;

   localparam logic [1:0] CC_ZERO = 2'd0;
   localparam logic [1:0] CC_LOW  = 2'd1;
   localparam logic [1:0] CC_EQ   = 2'd2;
   localparam logic [1:0] CC_HIGH = 2'd3;

endpackage
`default_nettype wire

/* rtl/rfa_ram.sv */
`default_nettype none
module rfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

/* rtl/rfa_front.sv */
`default_nettype none
module rfa_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   output      logic             req_full,
   input  wire rfa_pkg::req_type req_data,
   output      logic             job_valid,
   input  wire logic             job_take,
   output      rfa_pkg::job_type job
);
   import rfa_pkg::*;

   // two-entry queue of classified words
   job_type     q_ff [2];
   job_type     q_in [2];
   logic [1:0]  cnt_ff, cnt_in;
   logic        push_ok;
   job_type     new_job;

   assign req_full = cnt_ff[1];
   assign push_ok  = req_push && !req_full;
   assign job_valid = cnt_ff != 2'd0;
   assign job = q_ff[0];

   // classify: everything but the pure register ops touches memory
   always_comb begin
      new_job.req = req_data;
      unique case (req_data.command) inside
         CMD_CMR, CMD_AMR, CMD_SMR, CMD_LA: new_job.is_mem = 1'b0;
         default:                           new_job.is_mem = 1'b1;
      endcase
   end

   // shift on pop, append on push
   always_comb begin
      q_in[0] = q_ff[0];
      q_in[1] = q_ff[1];
      cnt_in  = cnt_ff;
      if (job_take && job_valid) begin
         q_in[0] = q_ff[1];
         cnt_in  = cnt_ff - 2'd1;
      end
      if (push_ok) begin
         if (cnt_in == 2'd0) q_in[0] = new_job;
         else                q_in[1] = new_job;
         cnt_in = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      q_ff[0] <= q_in[0];
      q_ff[1] <= q_in[1];
      if (reset) cnt_ff <= 2'd0;
      else       cnt_ff <= cnt_in;
   end
endmodule
`default_nettype wire

/* rtl/rfa_back.sv */
`default_nettype none
module rfa_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             job_valid,
   output      logic             job_take,
   input  wire rfa_pkg::job_type job,
   output      logic             rsp_empty,
   input  wire logic             rsp_pop,
   output      rfa_pkg::rsp_type rsp_data
);
   import rfa_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_RD   = 6'b000010,   // issue read of step byte(s), or first store write
      ST_WAIT = 6'b000100,   // read data lands
      ST_EVAL = 6'b001000,   // act on read data
      ST_WR2  = 6'b010000,   // second store byte
      ST_DONE = 6'b100000
   } st_type;

   st_type       st_ff, st_in;
   req_type      r_ff, r_in;
   logic [15:0]  i_ff, i_in;        // step index
   logic [15:0]  acc_ff, acc_in;    // result register
   logic         found_ff, found_in;
   logic [1:0]   cc_ff, cc_in;
   logic         ch_ff, ch_in, cl_ff, cl_in;
   logic         phase_ff, phase_in; // second read for two-byte ops
   logic [7:0]   b0_ff, b0_in;
   rsp_type      out_ff, out_in;
   logic         full_ff, full_in;

   logic              wr_en;
   logic [MEM_AW-1:0] wr_addr, rd_addr;
   logic [7:0]        wr_data, rd_data;
   logic [15:0]       ra16, wa16;
   logic [15:0]       off;
   logic [16:0]       sum;
   logic [15:0]       dif;
   logic [15:0]       sres;
   rsp_type           fin;
   logic              can_fin;

   rfa_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   assign rsp_empty = !full_ff;
   assign rsp_data  = out_ff;
   assign can_fin   = !full_ff || rsp_pop;
   assign job_take  = (st_ff == ST_IDLE) && job_valid && can_fin;
   assign sum  = {1'b0, job.req.reg_value} + {1'b0, job.req.operand};
   assign dif  = job.req.reg_value - job.req.operand;
   // digit compare walks from the left: offset counts down
   assign off  = {8'd0, r_ff.length[7:0]} - 16'd1 - i_ff;

   // memory address of the current step
   always_comb begin
      ra16 = r_ff.addr_a;
      case (r_ff.command)
         CMD_LDR: ra16 = r_ff.addr_a + {15'd0, phase_ff};
         CMD_SR:  ra16 = r_ff.addr_a + i_ff;
         CMD_SL:  ra16 = r_ff.addr_a - i_ff;
         CMD_MVQ: ra16 = phase_ff ? r_ff.addr_a - i_ff : r_ff.addr_b - i_ff;
         CMD_CMQ: ra16 = phase_ff ? r_ff.addr_b - off : r_ff.addr_a - off;
         default: ra16 = r_ff.addr_a;
      endcase
      rd_addr = MEM_AW'(ra16);
   end

   // memory writes
   always_comb begin
      wr_en = 1'b0;
      wa16  = r_ff.addr_a;
      wr_data = r_ff.byte_value;
      if (st_ff == ST_RD && r_ff.command == CMD_WRB) begin
         wr_en = 1'b1;
      end else if (st_ff == ST_RD && r_ff.command == CMD_STR) begin
         wr_en = 1'b1;
         wr_data = r_ff.reg_value[15:8];
      end else if (st_ff == ST_WR2) begin
         wr_en = 1'b1;
         wa16 = r_ff.addr_a + 16'd1;
         wr_data = r_ff.reg_value[7:0];
      end else if (st_ff == ST_EVAL && r_ff.command == CMD_MVQ && phase_ff) begin
         wr_en = 1'b1;
         wa16 = r_ff.addr_a - i_ff;
         wr_data = {rd_data[7:4], b0_ff[3:0]};
      end
      wr_addr = MEM_AW'(wa16);
   end

   assign sres = (r_ff.command == CMD_SR) ? r_ff.addr_a + i_ff + 16'd1
                                          : r_ff.addr_a - i_ff - 16'd1;

   // sequencer
   always_comb begin
      st_in = st_ff; r_in = r_ff; i_in = i_ff; acc_in = acc_ff;
      found_in = found_ff; cc_in = cc_ff; ch_in = ch_ff; cl_in = cl_ff;
      phase_in = phase_ff; b0_in = b0_ff;
      out_in = out_ff; full_in = full_ff;
      fin = '0;
      fin.cond_code = cc_ff; fin.carry_high = ch_ff; fin.carry_into_msb = cl_ff;
      if (full_ff && rsp_pop) full_in = 1'b0;

      unique case (st_ff)
         ST_IDLE: begin
            if (job_take) begin
               r_in = job.req; i_in = '0; phase_in = 1'b0;
               found_in = 1'b0;
               if (job.is_mem) begin
                  st_in = ST_RD;
               end else begin
                  // register ops finish right away
                  case (job.req.command)
                     CMD_CMR: begin
                        cc_in = (job.req.reg_value < job.req.operand) ? CC_LOW :
                                (job.req.reg_value == job.req.operand) ? CC_EQ : CC_HIGH;
                     end
                     CMD_AMR: begin
                        ch_in = sum[16];
                        cl_in = 1'({1'b0, job.req.reg_value[14:0]}
                                   + {1'b0, job.req.operand[14:0]} >> 15);
                        cc_in = {sum[16], sum[15:0] != 16'd0};
                        fin.reg_out = sum[15:0]; fin.reg_valid = 1'b1;
                     end
                     CMD_SMR: begin
                        ch_in = job.req.reg_value < job.req.operand;
                        cl_in = job.req.reg_value[14:0] < job.req.operand[14:0];
                        cc_in = dif[15] ? CC_LOW : (dif == 16'd0 ? CC_EQ : CC_HIGH);
                        fin.reg_out = dif; fin.reg_valid = 1'b1;
                     end
                     CMD_LA: begin
                        fin.reg_out = job.req.addr_a; fin.reg_valid = 1'b1;
                     end
                     default: ;
                  endcase
                  fin.cond_code = cc_in; fin.carry_high = ch_in;
                  fin.carry_into_msb = cl_in;
                  out_in = fin; full_in = 1'b1;
               end
            end
         end
         ST_RD: begin
            case (r_ff.command) inside
               CMD_WRB: st_in = ST_DONE;
               CMD_STR: st_in = ST_WR2;
               CMD_SR, CMD_SL: begin
                  if (i_ff == r_ff.length) begin
                     acc_in = (r_ff.command == CMD_SR) ? r_ff.addr_a + r_ff.length
                                                      : r_ff.addr_a - r_ff.length;
                     st_in = ST_DONE;
                  end else st_in = ST_WAIT;
               end
               CMD_MVQ, CMD_CMQ: begin
                  if (i_ff == {8'd0, r_ff.length[7:0]}) st_in = ST_DONE;
                  else                                   st_in = ST_WAIT;
               end
               CMD_RDB, CMD_LDR: st_in = ST_WAIT;
               default: st_in = ST_DONE;
            endcase
         end
         ST_WAIT: st_in = ST_EVAL;
         ST_EVAL: begin
            st_in = ST_RD;
            case (r_ff.command) inside
               CMD_RDB: begin b0_in = rd_data; st_in = ST_DONE; end
               CMD_LDR: begin
                  if (!phase_ff) begin b0_in = rd_data; phase_in = 1'b1; end
                  else begin acc_in = {b0_ff, rd_data}; st_in = ST_DONE; end
               end
               CMD_SR, CMD_SL: begin
                  if (rd_data == r_ff.byte_value) begin
                     found_in = 1'b1; acc_in = sres; st_in = ST_DONE;
                  end else i_in = i_ff + 16'd1;
               end
               CMD_MVQ: begin
                  if (!phase_ff) begin b0_in = rd_data; phase_in = 1'b1; end
                  else begin
                     if (b0_ff[3:0] != 4'd0) found_in = 1'b1;
                     phase_in = 1'b0; i_in = i_ff + 16'd1;
                  end
               end
               CMD_CMQ: begin
                  if (!phase_ff) begin b0_in = rd_data; phase_in = 1'b1; end
                  else if (b0_ff[3:0] != rd_data[3:0]) begin
                     found_in = 1'b1;
                     acc_in = {14'd0, (b0_ff[3:0] < rd_data[3:0]) ? CC_LOW : CC_HIGH};
                     st_in = ST_DONE;
                  end else begin
                     phase_in = 1'b0; i_in = i_ff + 16'd1;
                  end
               end
               default: st_in = ST_DONE;
            endcase
         end
         ST_WR2: st_in = ST_DONE;
         ST_DONE: begin
            if (can_fin) begin
               case (r_ff.command) inside
                  CMD_RDB: fin.read_data = b0_ff;
                  CMD_LDR: begin fin.reg_out = acc_ff; fin.reg_valid = 1'b1; end
                  CMD_SR, CMD_SL: begin
                     cc_in = found_ff ? CC_LOW : CC_ZERO;
                     fin.reg_out = acc_ff; fin.reg_valid = 1'b1;
                  end
                  CMD_MVQ: cc_in = found_ff ? CC_LOW : CC_ZERO;
                  CMD_CMQ: cc_in = found_ff ? acc_ff[1:0] : CC_EQ;
                  default: ;
               endcase
               fin.cond_code = cc_in;
               out_in = fin; full_in = 1'b1; st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      r_ff <= r_in; i_ff <= i_in; acc_ff <= acc_in; b0_ff <= b0_in;
      found_ff <= found_in; phase_ff <= phase_in; out_ff <= out_in;
      if (reset) begin
         st_ff <= ST_IDLE; full_ff <= 1'b0;
         cc_ff <= CC_ZERO; ch_ff <= 1'b0; cl_ff <= 1'b0;
      end else begin
         st_ff <= st_in; full_ff <= full_in;
         cc_ff <= cc_in; ch_ff <= ch_in; cl_ff <= cl_in;
      end
   end
endmodule
`default_nettype wire

/* rtl/register_and_field_alu_unit.sv */
// Flow: each pushed word is classified in the front queue; register ops finish
// as soon as the back end takes them, memory ops walk their bytes step by step
// (a search or compare stops on a hit).
// Throughput: one word at a time in the back end, register ops every cycle while
// each result is popped as it appears.
// Reset (synchronous, active high) clears cc, carry flags and queues.
`default_nettype none
module register_and_field_alu_unit (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   output      logic             full,
   input  wire rfa_pkg::req_type req_data,
   output      logic             empty,
   input  wire logic             pop,
   output      rfa_pkg::rsp_type rsp_data
);
   import rfa_pkg::*;

   logic    job_valid, job_take;
   job_type job;

   rfa_front u_front (
      .clock(clock), .reset(reset), .req_push(push), .req_full(full),
      .req_data(req_data), .job_valid(job_valid), .job_take(job_take), .job(job)
   );

   rfa_back u_back (
      .clock(clock), .reset(reset), .job_valid(job_valid), .job_take(job_take),
      .job(job), .rsp_empty(empty), .rsp_pop(pop), .rsp_data(rsp_data)
   );
endmodule
`default_nettype wire

/* rtl/rfa_checker.sv */
`default_nettype none
module rfa_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             full,
   input wire logic             empty,
   input wire logic             pop,
   input wire rfa_pkg::rsp_type rsp_data
);
   // a result word holds while it waits
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> $stable(rsp_data)) else $error("result changed");
   // empty right after reset
   a_rst: assert property (@(posedge clock) reset |=> empty)
      else $error("result after reset");
   // read data only without a register result
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_data.reg_valid |-> rsp_data.read_data == 8'd0)
      else $error("both register and read data");
   // not full right after reset
   a_full: assert property (@(posedge clock) reset |=> !full)
      else $error("full after reset");
endmodule

bind register_and_field_alu_unit rfa_checker u_chk (
   .clock(clock), .reset(reset), .full(full),
   .empty(empty), .pop(pop), .rsp_data(rsp_data)
);
`default_nettype wire
